/* rtl/core/sitda_pkg.sv */
// Shared types and constants for the signed integer to decimal ASCII block.
// No dependencies.
`default_nettype none

package sitda_pkg;

    localparam int NUM_BITS   = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CHAR_W     = 6;
    localparam int LEFT_W     = 4;
    localparam int CNT_W      = 5;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

    typedef logic [BCD_W-1:0]  t_bcd;
    typedef logic [CHAR_W-1:0] t_char;

    // Converter to emitter handoff.
    typedef struct packed {
        logic valid;
        logic neg;
        t_bcd bcd;
    } t_conv;

endpackage

`default_nettype wire

/* rtl/core/signed_int_to_decimal_ascii.sv */
// Top level: signed 32-bit integer to decimal ASCII character stream.
// Depends on sitda_pkg, sitda_dabble, sitda_emit.
//
// A value is taken when start is high and busy is low. Its magnitude runs
// through a bit-serial double-dabble converter, is handed to the character
// sequencer, and the text leaves one character per strobe, most significant
// first, with o_last on the final digit; the receiver cannot stall.
// The sequencer handles the minus sign first and then each of the ten BCD
// digit positions in turn, leading zero positions producing no strobe, so a
// value occupies the block from accept until its last digit has gone out.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [sitda_pkg::NUM_BITS-1:0] i_value,
    output logic                                      o_strobe,
    output logic [sitda_pkg::CHAR_W-1:0]              o_character,
    output logic                                      o_last
);

    logic             dab_busy;
    logic             emit_busy;
    logic             load;
    sitda_pkg::t_conv conv;

    assign busy = dab_busy | emit_busy;
    assign load = start & ~busy;

    sitda_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_value ($unsigned(i_value)),
        .o_busy  (dab_busy),
        .o_conv  (conv)
    );

    sitda_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_conv      (conv),
        .o_busy      (emit_busy),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> busy)
        else $error("busy not raised after accept");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_character == sitda_pkg::CHAR_MINUS) ||
                     (o_character >= sitda_pkg::CHAR_ZERO &&
                      o_character <= sitda_pkg::CHAR_NINE))
        else $error("character out of range");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_character == sitda_pkg::CHAR_MINUS) |-> !o_last)
        else $error("minus sign marked last");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("beat right after last character");

    a_conv_idle_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv.valid |-> !emit_busy)
        else $error("handoff while sequencer busy");

endmodule

`default_nettype wire

/* rtl/core/sitda_dabble.sv */
// Bit-serial double-dabble binary to BCD converter, one magnitude bit per cycle.
// Depends on sitda_pkg.
`default_nettype none

module sitda_dabble (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_load,
    input  wire logic [sitda_pkg::NUM_BITS-1:0]   i_value,
    output logic                                  o_busy,
    output sitda_pkg::t_conv                      o_conv
);

    logic                             r_busy;
    logic                             r_done;
    logic [sitda_pkg::CNT_W-1:0]      r_cnt;
    logic [sitda_pkg::NUM_BITS-1:0]   r_mag;
    sitda_pkg::t_bcd                  r_bcd;
    logic                             r_neg;
    sitda_pkg::t_bcd                  n_adj;

    always_comb begin
        for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_value[sitda_pkg::NUM_BITS-1];
                r_bcd  <= '0;
                if (i_value[sitda_pkg::NUM_BITS-1]) begin
                    r_mag <= '0 - i_value;
                end else begin
                    r_mag <= i_value;
                end
            end else if (r_busy) begin
                r_bcd <= {n_adj[sitda_pkg::BCD_W-2:0], r_mag[sitda_pkg::NUM_BITS-1]};
                r_mag <= {r_mag[sitda_pkg::NUM_BITS-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == sitda_pkg::CNT_W'(sitda_pkg::NUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy       = r_busy | r_done;
    assign o_conv.valid = r_done;
    assign o_conv.neg   = r_neg;
    assign o_conv.bcd   = r_bcd;

endmodule

`default_nettype wire

/* rtl/core/sitda_emit.sv */
// Character sequencer: shifts BCD digits out most significant first, drops leading zeros.
// Depends on sitda_pkg.
`default_nettype none

module sitda_emit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sitda_pkg::t_conv     i_conv,
    output logic                      o_busy,
    output logic                      o_strobe,
    output sitda_pkg::t_char          o_character,
    output logic                      o_last
);

    logic                             r_busy;
    logic                             r_neg;
    logic                             r_lead_done;
    logic [sitda_pkg::LEFT_W-1:0]     r_left;
    sitda_pkg::t_bcd                  r_bcd;
    logic                             r_strobe;
    sitda_pkg::t_char                 r_char;
    logic                             r_last;
    logic [3:0]                       n_top;

    assign n_top = r_bcd[sitda_pkg::BCD_W-1 -: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_neg    <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_conv.valid) begin
                r_busy      <= 1'b1;
                r_neg       <= i_conv.neg;
                r_bcd       <= i_conv.bcd;
                r_left      <= sitda_pkg::LEFT_W'(sitda_pkg::NUM_DIGITS);
                r_lead_done <= 1'b0;
            end else if (r_busy) begin
                if (r_neg) begin
                    r_strobe <= 1'b1;
                    r_char   <= sitda_pkg::CHAR_MINUS;
                    r_last   <= 1'b0;
                    r_neg    <= 1'b0;
                end else begin
                    r_bcd  <= {r_bcd[sitda_pkg::BCD_W-5:0], 4'd0};
                    r_left <= r_left - 1'b1;
                    // leading zero positions are dropped, the units digit always goes out
                    if (r_lead_done || n_top != 4'd0 || r_left == 4'd1) begin
                        r_strobe    <= 1'b1;
                        r_char      <= sitda_pkg::CHAR_ZERO | {2'b00, n_top};
                        r_last      <= (r_left == 4'd1);
                        r_lead_done <= 1'b1;
                    end
                    if (r_left == 4'd1) begin
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

`default_nettype wire
